// ----- rtl/pn_pkg.sv -----
// Shared types and constants for the path normaliser.
package pn_pkg;

    localparam int MAX_PATH = 128;

    localparam logic [7:0]  LIMIT_MAX      = 8'(MAX_PATH);
    localparam logic [7:0]  COMP_SATURATE  = 8'(MAX_PATH + 1);
    localparam logic [15:0] BUF_SIZE_RESET = 16'd256;

    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;
    localparam logic [7:0] BYTE_DOT   = 8'h2E;
    localparam logic [7:0] BYTE_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_PARENT      = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_TOO_LONG    = 2'd3
    } status_t;

    typedef struct packed {
        logic       sep_write;
        logic [6:0] sep_address;
        logic       char_write;
        logic [6:0] char_address;
        logic [7:0] out_char;
        logic       done_res;
        status_t    status;
        logic [7:0] path_length;
    } result_t;

endpackage

// ----- rtl/pn_classify.sv -----
// Byte classifier that flags bytes not allowed in a path component.
module pn_classify
(
    input  logic [7:0] in_byte,
    output logic       rejected
);

    // Control bytes, space, bytes beyond the tilde and the shell characters
    // \ ' " * ? [ ] { } $ % ! ^ ~ ` ; | & < > are all refused.
    always_comb
    begin
        if (in_byte <= pn_pkg::BYTE_SPACE || in_byte > pn_pkg::BYTE_TILDE)
        begin
            rejected = 1'b1;
        end
        else
        begin
            case (in_byte)
                8'h5C, 8'h27, 8'h22, 8'h2A, 8'h3F,
                8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h24,
                8'h25, 8'h21, 8'h5E, 8'h7E, 8'h60,
                8'h3B, 8'h7C, 8'h26, 8'h3C, 8'h3E: rejected = 1'b1;
                default:                           rejected = 1'b0;
            endcase
        end
    end

endmodule

// ----- rtl/pn_engine.sv -----
// Per-path state and the single-pass step logic of the path normaliser.
module pn_engine
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        in_byte,
    input  logic [15:0]       buffer_size,
    output pn_pkg::result_t   result
);

    logic [7:0]      committed_reg, committed_next;
    logic [7:0]      component_reg, component_next;
    logic [1:0]      dot_reg, dot_next;
    pn_pkg::status_t status_reg, status_next;
    logic            start_reg, start_next;

    logic            rejected;
    logic [7:0]      limit;
    logic [7:0]      comm_v;
    pn_pkg::status_t stat_v;
    logic            sep_flag;
    logic [8:0]      total;
    logic [8:0]      pos;

    pn_classify u_classify
    (
        .in_byte  (in_byte),
        .rejected (rejected)
    );

    always_comb
    begin
        if (buffer_size < 16'd2)
        begin
            limit = 8'd0;
        end
        else if (buffer_size > 16'(pn_pkg::MAX_PATH))
        begin
            limit = pn_pkg::LIMIT_MAX;
        end
        else
        begin
            limit = buffer_size[7:0] - 8'd1;
        end
    end

    always_comb
    begin
        comm_v         = committed_reg;
        stat_v         = status_reg;
        component_next = component_reg;
        dot_next       = dot_reg;
        start_next     = start_reg;
        result         = '0;
        sep_flag       = 1'b0;
        total          = '0;
        pos            = '0;

        if (start_reg)
        begin
            start_next = 1'b0;
            if (buffer_size < 16'd2)
            begin
                stat_v = pn_pkg::ST_TOO_LONG;
            end
            else
            begin
                comm_v             = 8'd1;
                result.sep_write   = 1'b1;
                result.sep_address = 7'd0;
            end
        end

        sep_flag = (comm_v > 8'd1);
        total    = {1'b0, comm_v} + {8'd0, sep_flag} + {1'b0, component_reg};
        pos      = total;

        if (in_byte == pn_pkg::BYTE_NUL || (in_byte == pn_pkg::BYTE_SLASH
                                            && stat_v == pn_pkg::ST_OK))
        begin
            if (stat_v == pn_pkg::ST_OK && component_reg != 8'd0)
            begin
                if (component_reg == 8'd1 && dot_reg[0])
                begin
                    stat_v = pn_pkg::ST_OK;
                end
                else if (component_reg == 8'd2 && dot_reg == 2'b11)
                begin
                    stat_v = pn_pkg::ST_PARENT;
                end
                else if (total > {1'b0, limit})
                begin
                    stat_v = pn_pkg::ST_TOO_LONG;
                end
                else
                begin
                    comm_v = total[7:0];
                end
                component_next = 8'd0;
                dot_next       = 2'b00;
            end
            result.done_res = (in_byte == pn_pkg::BYTE_NUL);
        end
        else if (stat_v != pn_pkg::ST_OK)
        begin
            stat_v = stat_v;
        end
        else if (rejected)
        begin
            stat_v = pn_pkg::ST_UNSUPPORTED;
        end
        else
        begin
            if (component_reg == 8'd0 && sep_flag && comm_v < limit)
            begin
                result.sep_write   = 1'b1;
                result.sep_address = comm_v[6:0];
            end
            if (pos < {1'b0, limit})
            begin
                result.char_write   = 1'b1;
                result.char_address = pos[6:0];
                result.out_char     = in_byte;
            end
            if (in_byte == pn_pkg::BYTE_DOT)
            begin
                if (component_reg == 8'd0)
                begin
                    dot_next = dot_reg | 2'b01;
                end
                else if (component_reg == 8'd1)
                begin
                    dot_next = dot_reg | 2'b10;
                end
            end
            if (component_reg < pn_pkg::COMP_SATURATE)
            begin
                component_next = component_reg + 8'd1;
            end
        end

        result.status      = stat_v;
        result.path_length = comm_v;

        committed_next = comm_v;
        status_next    = stat_v;
        if (result.done_res)
        begin
            committed_next = 8'd0;
            component_next = 8'd0;
            dot_next       = 2'b00;
            status_next    = pn_pkg::ST_OK;
            start_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_reg <= 8'd0;
            component_reg <= 8'd0;
            dot_reg       <= 2'b00;
            status_reg    <= pn_pkg::ST_OK;
            start_reg     <= 1'b1;
        end
        else if (fire)
        begin
            committed_reg <= committed_next;
            component_reg <= component_next;
            dot_reg       <= dot_next;
            status_reg    <= status_next;
            start_reg     <= start_next;
        end
    end

    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status_reg != pn_pkg::ST_OK && in_byte != pn_pkg::BYTE_NUL)
        |=> (status_reg == $past(status_reg)))
        else $error("Path status changed after an error before the terminator.");

    a_committed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        committed_reg <= pn_pkg::LIMIT_MAX)
        else $error("Committed length exceeds the maximum path length.");

    a_component_bound: assert property (@(posedge clk) disable iff (!rst_n)
        component_reg <= pn_pkg::COMP_SATURATE)
        else $error("Component length exceeds its saturation value.");

    a_char_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.char_write) |-> ({1'b0, result.char_address} < limit))
        else $error("Component byte written at or beyond the usable limit.");

    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.done_res) |=> (start_reg && committed_reg == 8'd0))
        else $error("Per-path state not cleared after the terminator.");

endmodule

// ----- rtl/path_normalizer.sv -----
// Top level of the streaming path normaliser with its handshake registers.
//
// Usage: a path arrives one byte per word on the in_valid/in_ready channel,
// a zero byte ending the path. Every accepted word yields exactly one result
// word on the out_valid/out_ready channel, carrying the separator and
// component byte writes for the destination buffer, and on the terminator
// the final status and committed length.
// The buffer_size register is written through cfg_valid/cfg_ready, which is
// always ready; it should be changed only while no path word is in flight.
// A word accepted into the input register is stepped by combinational logic
// and its result word is captured in the result register on fire. Throughput
// is one word per cycle while the receiver does not stall, set by the single
// step of combinational logic between the two registers.
// When the receiver stalls, the result register holds and the input register
// takes one further word if it was empty, after which in_ready falls.
// Reset clears the valid flags of both registers, sets buffer_size to 256 and
// readies the block for the start of a new path.
module path_normalizer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        sep_write,
    output logic [6:0]  sep_address,
    output logic        char_write,
    output logic [6:0]  char_address,
    output logic [7:0]  out_char,
    output logic        done_res,
    output logic [1:0]  status,
    output logic [7:0]  path_length,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] buffer_size
);

    logic               hold_valid_reg;
    logic [7:0]         hold_byte_reg;
    logic               out_valid_reg;
    pn_pkg::result_t    result_reg;
    pn_pkg::result_t    step_result;
    logic [15:0]        buf_size_reg;
    logic               fire;

    assign fire      = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !hold_valid_reg || fire;
    assign cfg_ready = 1'b1;

    pn_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .in_byte     (hold_byte_reg),
        .buffer_size (buf_size_reg),
        .result      (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_size_reg <= pn_pkg::BUF_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            buf_size_reg <= buffer_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                hold_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_byte_reg <= in_byte;
        end
        if (fire)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sep_write    = result_reg.sep_write;
    assign sep_address  = result_reg.sep_address;
    assign char_write   = result_reg.char_write;
    assign char_address = result_reg.char_address;
    assign out_char     = result_reg.out_char;
    assign done_res     = result_reg.done_res;
    assign status       = result_reg.status;
    assign path_length  = result_reg.path_length;

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg
                                           && result_reg == $past(result_reg)))
        else $error("Result word changed or dropped while the receiver stalled.");

    a_hold_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !out_valid_reg) |-> fire)
        else $error("Input word held although the result register is empty.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !hold_valid_reg |-> in_ready)
        else $error("Input not ready although the input register is empty.");

endmodule
